/* sv/csqp_pkg.sv */
// Shared types and constants of the complex square root datapath.
// Used by the divider and the top level; depends on nothing.
package csqp_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_ADM = 2'd1,
    ST_SAT      = 2'd2
  } status_e;

  localparam logic ACT_QUOT = 1'b0;
  localparam logic ACT_PROD = 1'b1;

  localparam int MAG_W  = 64;
  localparam int QUO_W  = 65;
  localparam int ROOT_W = 32;

  typedef struct packed {
    logic a_neg;
    logic b_neg;
    logic adm_zero;
    logic eom;
  } div_side_t;

  typedef struct packed {
    logic [63:0] a_mag;
    logic        a_neg;
    logic        b_neg;
    logic        sat;
    logic        adm_zero;
    logic        eom;
  } mag_side_t;

  typedef struct packed {
    logic b_neg;
    logic sat;
    logic adm_zero;
    logic eom;
  } root_side_t;

  typedef struct packed {
    logic [31:0] root_re;
    logic [31:0] root_im;
    status_e     status;
    logic        eom;
  } result_t;

endpackage

/* sv/csqp_div.sv */
// Two-lane pipelined restoring divider with a shared divisor, one quotient bit per stage.
// Depends on csqp_pkg for the magnitude and quotient widths.
module csqp_div #(
  parameter int NUM_W  = 96,
  parameter int SIDE_W = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [1:0][NUM_W-1:0]                num_i,
  input  logic [csqp_pkg::MAG_W-1:0]           den_i,
  input  logic [SIDE_W-1:0]                    side_i,
  output logic                                 valid_o,
  output logic [1:0][csqp_pkg::QUO_W-1:0]      quo_o,
  output logic [1:0]                           ovf_o,
  output logic [SIDE_W-1:0]                    side_o
);

  localparam int MW    = csqp_pkg::MAG_W;
  localparam int QW    = csqp_pkg::QUO_W;
  localparam int HI_W  = NUM_W - QW;
  localparam int STG   = QW + 1;
  localparam int LANES = 2;

  logic [LANES-1:0][MW-1:0] rem_q  [STG];
  logic [LANES-1:0][QW-1:0] low_q  [STG];
  logic [LANES-1:0][QW-1:0] quo_q  [STG];
  logic [LANES-1:0]         ovf_q  [STG];
  logic [MW-1:0]            den_q  [STG];
  logic [SIDE_W-1:0]        side_q [STG];
  logic                     vld_q  [STG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane0
    logic [HI_W-1:0] hi;
    assign hi = num_i[l][NUM_W-1:QW];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[0][l] <= MW'(hi);
        low_q[0][l] <= num_i[l][QW-1:0];
        quo_q[0][l] <= '0;
        ovf_q[0][l] <= (MW'(hi) >= den_i);
      end
    end
  end

  for (genvar k = 1; k < STG; k++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [MW:0] rem_sh;
      logic [MW:0] diff;
      logic        ge;
      assign rem_sh = {rem_q[k-1][l], low_q[k-1][l][QW-1]};
      assign diff   = rem_sh - {1'b0, den_q[k-1]};
      assign ge     = (rem_sh >= {1'b0, den_q[k-1]});
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][l] <= ge ? diff[MW-1:0] : rem_sh[MW-1:0];
          quo_q[k][l] <= {quo_q[k-1][l][QW-2:0], ge};
          low_q[k][l] <= {low_q[k-1][l][QW-2:0], 1'b0};
          ovf_q[k][l] <= ovf_q[k-1][l];
        end
      end
    end
  end

  assign valid_o = vld_q[STG-1];
  assign quo_o   = quo_q[STG-1];
  assign ovf_o   = ovf_q[STG-1];
  assign side_o  = side_q[STG-1];

endmodule

/* sv/csqp_isqrt.sv */
// Multi-lane pipelined integer square root, one result bit per stage.
// Standalone; the caller supplies a side vector that travels with each item.
module csqp_isqrt #(
  parameter int IN_W   = 128,
  parameter int LANES  = 1,
  parameter int SIDE_W = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [LANES-1:0][IN_W-1:0]        x_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              valid_o,
  output logic [LANES-1:0][IN_W/2-1:0]      root_o,
  output logic [SIDE_W-1:0]                 side_o
);

  localparam int OUT_W  = IN_W / 2;
  localparam int REM_W  = OUT_W + 3;
  localparam int STAGES = OUT_W;

  logic [LANES-1:0][REM_W-1:0] rem_q  [STAGES];
  logic [LANES-1:0][OUT_W-1:0] root_q [STAGES];
  logic [LANES-1:0][IN_W-1:0]  x_q    [STAGES];
  logic [SIDE_W-1:0]           side_q [STAGES];
  logic                        vld_q  [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [LANES-1:0][REM_W-1:0] rem_in;
    logic [LANES-1:0][OUT_W-1:0] root_in;
    logic [LANES-1:0][IN_W-1:0]  x_in;
    logic [SIDE_W-1:0]           side_in;
    logic                        vld_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign x_in    = x_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      assign rem_sh = {rem_in[l][REM_W-3:0], x_in[l][IN_W-1 -: 2]};
      assign trial  = {1'b0, root_in[l], 2'b01};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (rem_sh >= trial) begin
            rem_q[k][l]  <= rem_sh - trial;
            root_q[k][l] <= {root_in[l][OUT_W-2:0], 1'b1};
          end else begin
            rem_q[k][l]  <= rem_sh;
            root_q[k][l] <= {root_in[l][OUT_W-2:0], 1'b0};
          end
          x_q[k][l] <= {x_in[l][IN_W-3:0], 2'b00};
        end
      end
    end
  end

  assign valid_o = vld_q[STAGES-1];
  assign root_o  = root_q[STAGES-1];
  assign side_o  = side_q[STAGES-1];

endmodule

/* sv/complex_sqrt_quotient_product.sv */
// Top level: principal complex root of Z/Y or Z*Y for a stream of matrix elements.
// Depends on csqp_pkg, csqp_div and csqp_isqrt.
//
//   channel | direction | handshake             | payload
//   in      | to block  | in_valid_i/in_stall_o | action, z_re, z_im, y_re, y_im, end_of_matrix
//   out     | from block| out_valid_o/out_stall_i| root_re, root_im, status, end_of_matrix_out
//
// One element enters per cycle while in_stall_o is low; each result leaves through the output register.
// The datapath runs through the 66-stage divider and the 64- and 32-stage root pipelines.
// Reset clears every valid bit; no data register is reset.
// A stalled result waits in the output register; the next one goes to a skid register,
// and only when that is full does the whole pipeline freeze and in_stall_o rise.
module complex_sqrt_quotient_product #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic signed [31:0] z_re_i,
  input  logic signed [31:0] z_im_i,
  input  logic signed [31:0] y_re_i,
  input  logic signed [31:0] y_im_i,
  input  logic               end_of_matrix_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] root_re_o,
  output logic signed [31:0] root_im_o,
  output logic [1:0]         status_o,
  output logic               end_of_matrix_out_o
);

  localparam int DIV_NUM_W = csqp_pkg::MAG_W + 2 * FRAC_BITS;

  logic en;
  logic skid_v_q;
  logic out_v_q;
  csqp_pkg::result_t out_q;
  csqp_pkg::result_t skid_q;
  csqp_pkg::result_t res;

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // Stage 1: products.
  logic               s1_v_q;
  logic signed [63:0] s1_rr_q, s1_ii_q, s1_ri_q, s1_ir_q, s1_yy_q, s1_jj_q;
  logic               s1_act_q, s1_eom_q, s1_yzero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_rr_q    <= z_re_i * y_re_i;
      s1_ii_q    <= z_im_i * y_im_i;
      s1_ri_q    <= z_re_i * y_im_i;
      s1_ir_q    <= z_im_i * y_re_i;
      s1_yy_q    <= y_re_i * y_re_i;
      s1_jj_q    <= y_im_i * y_im_i;
      s1_act_q   <= action_i;
      s1_eom_q   <= end_of_matrix_i;
      s1_yzero_q <= (y_re_i == 32'sd0) && (y_im_i == 32'sd0);
    end
  end

  // Stage 2: sums and divisor. Product mode divides by one in Q2F so the divider passes through.
  logic               s2_v_q;
  logic signed [64:0] s2_a_q, s2_b_q;
  logic [63:0]        s2_den_q;
  logic               s2_zero_q, s2_eom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_eom_q <= s1_eom_q;
      if (s1_act_q == csqp_pkg::ACT_PROD) begin
        s2_a_q    <= 65'(s1_rr_q) - 65'(s1_ii_q);
        s2_b_q    <= 65'(s1_ri_q) + 65'(s1_ir_q);
        s2_den_q  <= 64'd1 << (2 * FRAC_BITS);
        s2_zero_q <= 1'b0;
      end else begin
        s2_a_q    <= 65'(s1_rr_q) + 65'(s1_ii_q);
        s2_b_q    <= 65'(s1_ir_q) - 65'(s1_ri_q);
        s2_den_q  <= s1_yzero_q ? 64'd1 : ($unsigned(s1_yy_q) + $unsigned(s1_jj_q));
        s2_zero_q <= s1_yzero_q;
      end
    end
  end

  // Stage 3: sign and magnitude.
  logic        s3_v_q;
  logic [63:0] s3_amag_q, s3_bmag_q, s3_den_q;
  logic [64:0] a_neg_val, b_neg_val;
  csqp_pkg::div_side_t s3_side_q;

  assign a_neg_val = -s2_a_q;
  assign b_neg_val = -s2_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_amag_q          <= s2_a_q[64] ? a_neg_val[63:0] : s2_a_q[63:0];
      s3_bmag_q          <= s2_b_q[64] ? b_neg_val[63:0] : s2_b_q[63:0];
      s3_den_q           <= s2_den_q;
      s3_side_q.a_neg    <= s2_a_q[64];
      s3_side_q.b_neg    <= s2_b_q[64];
      s3_side_q.adm_zero <= s2_zero_q;
      s3_side_q.eom      <= s2_eom_q;
    end
  end

  // Division of the scaled magnitudes.
  logic [1:0][DIV_NUM_W-1:0]          div_num;
  logic                               div_v;
  logic [1:0][csqp_pkg::QUO_W-1:0]    div_quo;
  logic [1:0]                         div_ovf;
  csqp_pkg::div_side_t                div_side;

  assign div_num[0] = {s3_amag_q, {(2 * FRAC_BITS){1'b0}}};
  assign div_num[1] = {s3_bmag_q, {(2 * FRAC_BITS){1'b0}}};

  csqp_div #(
    .NUM_W  (DIV_NUM_W),
    .SIDE_W ($bits(csqp_pkg::div_side_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_v_q),
    .num_i   (div_num),
    .den_i   (s3_den_q),
    .side_i  (s3_side_q),
    .valid_o (div_v),
    .quo_o   (div_quo),
    .ovf_o   (div_ovf),
    .side_o  (div_side)
  );

  // Stage 4: clamp quotients to 2^63.
  logic        s4_v_q;
  logic [63:0] s4_amag_q, s4_bmag_q;
  logic        s4_aneg_q, s4_bneg_q, s4_sat_q, s4_zero_q, s4_eom_q;
  logic [1:0]  qsat;
  logic [1:0][63:0] qmag;

  for (genvar l = 0; l < 2; l++) begin : g_qsat
    assign qsat[l] = div_ovf[l] | div_quo[l][64] | (div_quo[l][63] & (|div_quo[l][62:0]));
    assign qmag[l] = qsat[l] ? {1'b1, 63'd0} : div_quo[l][63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_amag_q <= qmag[0];
      s4_bmag_q <= qmag[1];
      s4_aneg_q <= div_side.a_neg & (|qmag[0]);
      s4_bneg_q <= div_side.b_neg & (|qmag[1]);
      s4_sat_q  <= |qsat;
      s4_zero_q <= div_side.adm_zero;
      s4_eom_q  <= div_side.eom;
    end
  end

  // Stages 5 to 7: a^2 + b^2 from 32-bit partial products.
  logic        s5_v_q, s6_v_q, s7_v_q;
  logic [63:0] s5_a11_q, s5_a10_q, s5_a00_q, s5_b11_q, s5_b10_q, s5_b00_q;
  logic [127:0] s6_a2_q, s6_b2_q, s7_sum_q;
  csqp_pkg::mag_side_t s5_side_q, s6_side_q, s7_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
      s7_v_q <= 1'b0;
    end else if (en) begin
      s5_v_q <= s4_v_q;
      s6_v_q <= s5_v_q;
      s7_v_q <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_a11_q           <= s4_amag_q[63:32] * s4_amag_q[63:32];
      s5_a10_q           <= s4_amag_q[63:32] * s4_amag_q[31:0];
      s5_a00_q           <= s4_amag_q[31:0] * s4_amag_q[31:0];
      s5_b11_q           <= s4_bmag_q[63:32] * s4_bmag_q[63:32];
      s5_b10_q           <= s4_bmag_q[63:32] * s4_bmag_q[31:0];
      s5_b00_q           <= s4_bmag_q[31:0] * s4_bmag_q[31:0];
      s5_side_q.a_mag    <= s4_amag_q;
      s5_side_q.a_neg    <= s4_aneg_q;
      s5_side_q.b_neg    <= s4_bneg_q;
      s5_side_q.sat      <= s4_sat_q;
      s5_side_q.adm_zero <= s4_zero_q;
      s5_side_q.eom      <= s4_eom_q;
      s6_a2_q   <= {s5_a11_q, 64'd0} + (128'(s5_a10_q) << 33) + 128'(s5_a00_q);
      s6_b2_q   <= {s5_b11_q, 64'd0} + (128'(s5_b10_q) << 33) + 128'(s5_b00_q);
      s6_side_q <= s5_side_q;
      s7_sum_q  <= s6_a2_q + s6_b2_q;
      s7_side_q <= s6_side_q;
    end
  end

  // Modulus r.
  logic                 mod_v;
  logic [0:0][63:0]     mod_r;
  logic [0:0][127:0]    mod_x;
  csqp_pkg::mag_side_t  mod_side;

  assign mod_x[0] = s7_sum_q;

  csqp_isqrt #(
    .IN_W   (128),
    .LANES  (1),
    .SIDE_W ($bits(csqp_pkg::mag_side_t))
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s7_v_q),
    .x_i     (mod_x),
    .side_i  (s7_side_q),
    .valid_o (mod_v),
    .root_o  (mod_r),
    .side_o  (mod_side)
  );

  // Stage 8: half of r + a and r - a.
  logic        s8_v_q;
  logic [64:0] sp, sm;
  logic [1:0][63:0] s8_x_q;
  csqp_pkg::root_side_t s8_side_q;

  assign sp = mod_side.a_neg ? (65'(mod_r[0]) - 65'(mod_side.a_mag))
                             : (65'(mod_r[0]) + 65'(mod_side.a_mag));
  assign sm = mod_side.a_neg ? (65'(mod_r[0]) + 65'(mod_side.a_mag))
                             : (65'(mod_r[0]) - 65'(mod_side.a_mag));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_v_q <= 1'b0;
    end else if (en) begin
      s8_v_q <= mod_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_x_q[0]          <= sp[64:1];
      s8_x_q[1]          <= sm[64:1];
      s8_side_q.b_neg    <= mod_side.b_neg;
      s8_side_q.sat      <= mod_side.sat;
      s8_side_q.adm_zero <= mod_side.adm_zero;
      s8_side_q.eom      <= mod_side.eom;
    end
  end

  // Real and imaginary roots.
  logic                 fin_v;
  logic [1:0][31:0]     fin_root;
  csqp_pkg::root_side_t fin_side;

  csqp_isqrt #(
    .IN_W   (64),
    .LANES  (2),
    .SIDE_W ($bits(csqp_pkg::root_side_t))
  ) u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s8_v_q),
    .x_i     (s8_x_q),
    .side_i  (s8_side_q),
    .valid_o (fin_v),
    .root_o  (fin_root),
    .side_o  (fin_side)
  );

  // Clamp, sign and status.
  logic [31:0] re_c, im_c, im_s;
  logic        re_sat, im_sat;

  assign re_sat = fin_root[0][csqp_pkg::ROOT_W-1];
  assign im_sat = fin_root[1][csqp_pkg::ROOT_W-1];
  assign re_c   = re_sat ? 32'h7FFF_FFFF : fin_root[0];
  assign im_c   = im_sat ? 32'h7FFF_FFFF : fin_root[1];
  assign im_s   = fin_side.b_neg ? (32'd0 - im_c) : im_c;

  always_comb begin
    res.eom = fin_side.eom;
    if (fin_side.adm_zero) begin
      res.root_re = '0;
      res.root_im = '0;
      res.status  = csqp_pkg::ST_ZERO_ADM;
    end else begin
      res.root_re = re_c;
      res.root_im = im_s;
      res.status  = (fin_side.sat | re_sat | im_sat) ? csqp_pkg::ST_SAT : csqp_pkg::ST_OK;
    end
  end

  // Output register and skid register.
  logic take;
  assign take = out_v_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        skid_v_q <= 1'b0;
      end
    end else if (fin_v) begin
      if (out_v_q && !take) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (fin_v) begin
      if (out_v_q && !take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o         = out_v_q;
  assign root_re_o           = out_q.root_re;
  assign root_im_o           = out_q.root_im;
  assign status_o            = out_q.status;
  assign end_of_matrix_out_o = out_q.eom;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("Skid register holds a result while the output register is empty.");

  a_skid_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_stall_i && fin_v && !skid_v_q) |=> skid_v_q)
    else $error("A finished result arriving at a stalled output was not kept.");

  a_zero_adm_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (out_q.status == csqp_pkg::ST_ZERO_ADM)) |->
      (out_q.root_re == 32'd0) && (out_q.root_im == 32'd0))
    else $error("Zero admittance result is not zero.");

  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (!out_q.root_re[31]) && (out_q.root_im != 32'h8000_0000))
    else $error("Root component outside the clamped range.");

endmodule
